// ===== rtl/rar_pkg.sv =====
// Shared types and constants for the rational arithmetic reduce block.
package rar_pkg;

	localparam int OPW = 16;
	localparam int NW  = OPW;
	localparam int DW  = OPW - 1;
	localparam int RNW = 2 * OPW;
	localparam int RDW = 2 * OPW - 1;
	localparam int KW  = $clog2(RNW);

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;
	localparam logic [1:0] MODE_DIV = 2'd3;

	localparam logic [1:0] CLS_FINITE = 2'd0;
	localparam logic [1:0] CLS_INF    = 2'd1;
	localparam logic [1:0] CLS_UNDEF  = 2'd2;

	typedef struct packed {
		logic [1:0]           mode;
		logic signed [NW-1:0] x_num;
		logic [DW-1:0]        x_den;
		logic signed [NW-1:0] y_num;
		logic [DW-1:0]        y_den;
	} rar_in_t;

	typedef struct packed {
		logic signed [RNW-1:0] res_num;
		logic [RDW-1:0]        res_den;
		logic [1:0]            res_class;
	} rar_out_t;

	typedef struct packed {
		logic signed [RNW-1:0] num;
		logic [RDW-1:0]        den;
		logic [1:0]            cls;
	} rar_work_t;

endpackage

// ===== rtl/rar_front.sv =====
// Front end: cross products, sign fix and classification of each word.
module rar_front import rar_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  rar_in_t   src_data,
	output logic      push,
	output rar_work_t word,
	input  logic      full
);

	logic                  valid_s1;
	logic [1:0]            mode_s1;
	logic signed [RNW-1:0] m1_s1, m2_s1, m3_s1;
	logic signed [NW-1:0]  xd_ext, yd_ext, op1, op3;
	logic signed [RNW-1:0] n, dmag;
	logic                  advance;

	assign xd_ext = $signed({1'b0, src_data.x_den});
	assign yd_ext = $signed({1'b0, src_data.y_den});
	assign op1 = (src_data.mode == MODE_MUL) ? src_data.y_num : yd_ext;
	assign op3 = (src_data.mode == MODE_DIV) ? src_data.y_num : yd_ext;

	assign push      = valid_s1 && !full;
	assign advance   = !valid_s1 || push;
	assign src_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && src_valid) begin
			mode_s1 <= src_data.mode;
			m1_s1   <= RNW'(src_data.x_num) * RNW'(op1);
			m2_s1   <= RNW'(src_data.y_num) * RNW'(xd_ext);
			m3_s1   <= RNW'(xd_ext) * RNW'(op3);
		end
	end

	// only a divide can give a negative denominator
	always_comb begin
		dmag = m3_s1[RNW-1] ? -m3_s1 : m3_s1;
		case (mode_s1)
			MODE_ADD: n = m1_s1 + m2_s1;
			MODE_SUB: n = m1_s1 - m2_s1;
			MODE_MUL: n = m1_s1;
			default:  n = m3_s1[RNW-1] ? -m1_s1 : m1_s1;
		endcase
		word.num = n;
		word.den = dmag[RDW-1:0];
		if (dmag == '0) begin
			word.cls = (n == '0) ? CLS_UNDEF : CLS_INF;
		end else begin
			word.cls = CLS_FINITE;
		end
	end

endmodule

// ===== rtl/rar_fifo.sv =====
// Two-entry queue between front end and reduction engine.
module rar_fifo import rar_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rar_work_t wdata,
	output logic      full,
	input  logic      pop,
	output rar_work_t rdata,
	output logic      empty
);

	rar_work_t  mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/rar_back.sv =====
// Reduction engine: binary GCD, then shared-divisor serial divide of both parts.
module rar_back import rar_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	output logic      pop,
	input  rar_work_t word,
	output logic      dst_valid,
	input  logic      dst_ready,
	output rar_out_t  dst_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GCD  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]     state_q;
	logic           sign_q;
	logic [1:0]     cls_q;
	logic [RNW-1:0] a_q, b_q, g_q, qn_q, qd_q, rn_q, rd_q;
	logic [KW-1:0]  k_q, cnt_q;
	logic           ovalid_q;
	rar_out_t       out_q;

	logic [RNW-1:0] mag, trial_n, trial_d;
	logic           bit_n, bit_d, load_out;

	assign pop       = (state_q == ST_IDLE) && !empty;
	assign mag       = word.num[RNW-1] ? RNW'(-word.num) : RNW'(word.num);
	assign trial_n   = {rn_q[RNW-2:0], qn_q[RNW-1]};
	assign trial_d   = {rd_q[RNW-2:0], qd_q[RNW-1]};
	assign bit_n     = (trial_n >= g_q);
	assign bit_d     = (trial_d >= g_q);
	assign load_out  = (state_q == ST_OUT) && (!ovalid_q || dst_ready);
	assign dst_valid = ovalid_q;
	assign dst_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (dst_ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= (word.cls == CLS_FINITE) ? ST_GCD : ST_OUT;
					end
				end
				ST_GCD: begin
					if (a_q == '0) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					sign_q <= word.num[RNW-1];
					cls_q  <= word.cls;
					qn_q   <= mag;
					qd_q   <= {1'b0, word.den};
					a_q    <= mag;
					b_q    <= {1'b0, word.den};
					k_q    <= '0;
				end
			end
			ST_GCD: begin
				if (a_q == '0) begin
					g_q   <= b_q << k_q;
					rn_q  <= '0;
					rd_q  <= '0;
					cnt_q <= KW'(RNW - 1);
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + KW'(1);
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q >= b_q) begin
					a_q <= (a_q - b_q) >> 1;
				end else begin
					b_q <= (b_q - a_q) >> 1;
				end
			end
			ST_DIV: begin
				rn_q  <= bit_n ? trial_n - g_q : trial_n;
				rd_q  <= bit_d ? trial_d - g_q : trial_d;
				qn_q  <= {qn_q[RNW-2:0], bit_n};
				qd_q  <= {qd_q[RNW-2:0], bit_d};
				cnt_q <= cnt_q - KW'(1);
			end
			default: begin
				if (load_out) begin
					out_q.res_num   <= sign_q ? -$signed(qn_q) : $signed(qn_q);
					out_q.res_den   <= qd_q[RDW-1:0];
					out_q.res_class <= cls_q;
				end
			end
		endcase
	end

endmodule

// ===== rtl/rational_arith_reduce_top.sv =====
// Top level of the rational arithmetic reduce block.
// Adds, subtracts, multiplies or divides two 16-bit fractions and returns the
// result reduced to lowest terms with a non-negative denominator; a zero
// denominator is passed through unreduced and flagged infinite or undefined.
// The front end takes a word per cycle while the queue is not full and feeds
// a two-entry queue; the reduction engine handles one word at a time: a pickup
// step, a binary GCD by subtract-or-shift steps (one per cycle), a restoring
// divide of both parts by the GCD, and a load of the output register, which
// waits while the previous result is still held and not yet taken.
// Words with a zero denominator skip the GCD and divide.
module rational_arith_reduce_top import rar_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     src_valid,
	output logic     src_ready,
	input  rar_in_t  src_data,
	output logic     dst_valid,
	input  logic     dst_ready,
	output rar_out_t dst_data
);

	logic      push, full, pop, empty;
	rar_work_t fwd_word, q_word;

	rar_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.push      (push),
		.word      (fwd_word),
		.full      (full)
	);

	rar_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (fwd_word),
		.full   (full),
		.pop    (pop),
		.rdata  (q_word),
		.empty  (empty)
	);

	rar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop       (pop),
		.word      (q_word),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

	a_finite_den: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.res_class == CLS_FINITE |-> dst_data.res_den != '0)
		else $error("finite result with zero denominator");

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.res_class == CLS_UNDEF |->
			dst_data.res_num == '0 && dst_data.res_den == '0)
		else $error("undefined result not 0/0");

	a_inf_form: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.res_class == CLS_INF |->
			dst_data.res_num != '0 && dst_data.res_den == '0)
		else $error("infinite result malformed");

endmodule
